// ===== src/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants of the bounded set table
// Holds the request mode codes, field widths and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned CAP_W  = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // Request modes; the two unused codes fall to the default arm.
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT    = 3'd0,
    MODE_REMOVE    = 3'd1,
    MODE_MEMBER    = 3'd2,
    MODE_POP       = 3'd3,
    MODE_ITER_RST  = 3'd4,
    MODE_ITER_NEXT = 3'd5
  } bst_mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // capture the request operand, restart the scan
    logic fetch_last;   // read the last stored entry
    logic fetch_iter;   // read the entry at the iteration pointer
    logic step;         // issue the next scan read
    logic shift_start;  // begin compaction after the matching entry
    logic shift_wr;     // write the pending read data one place down
    logic append;       // store the operand at the end, grow the count
    logic drop;         // shrink the count by one
    logic iter_clr;     // rewind the iteration pointer
    logic iter_inc;     // advance the iteration pointer
    logic res_load;     // latch the result of this request
    logic res_ok;       // success flag to latch
    logic res_data;     // take the value from the read data, else zero
    logic load_out;     // move the result into the output register
  } bst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // count has reached the effective capacity
    logic empty;      // count is zero
    logic iter_end;   // iteration pointer is at or past the end
    logic match;      // pending read data equals the operand
    logic scan_done;  // all entries read and compared
    logic out_free;   // output register can take a beat this cycle
  } bst_sts_t;

endpackage

// ===== src/bst_req_if.sv =====
// ----------------------------------------------------------------------------
// bst_req_if: request channel of the bounded set table
// Carries one request beat: a mode and an element operand.
// ----------------------------------------------------------------------------
interface bst_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] element;

  modport source (output valid, output mode, output element, input ready);
  modport sink   (input valid, input mode, input element, output ready);
endinterface

// ===== src/bst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bst_rsp_if: response channel of the bounded set table
// Carries one result beat: success flag, value, count and empty flag.
// ----------------------------------------------------------------------------
interface bst_rsp_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] value;
  logic [3:0]         count;
  logic               empty_res;

  modport source (output valid, output ok, output value, output count,
                  output empty_res, input ready);
  modport sink   (input valid, input ok, input value, input count,
                  input empty_res, output ready);
endinterface

// ===== src/bounded_set_table_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_set_table_unit: bounded set of distinct 32-bit elements
// Requests enter on req_i (mode and element), one result beat per request
// leaves on rsp_o (ok, value, count, empty_res). The capacity register is
// written through cfg_we_i / cfg_wdata_i; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Insert, remove and member scan the stored entries through the memory
// read port, one entry per cycle. Remove stops the scan at the match and
// then compacts the later entries, one per cycle. Pop and iterator next
// read one entry in the fetch state before the response state; iterator
// reset and the fast refusals (insert when full, pop or iterator next with
// nothing to return, unused modes) go straight to the response state.
// One request is in flight at a time; the next is accepted in the cycle
// after the result enters the output register, even while the receiver
// stalls. A stalled result holds in the output register, and the next
// result waits in the response state until the register is free.
// Reset empties the set, rewinds the iterator and sets the capacity to 8;
// entry contents are left as they are and are only read once written.
// ----------------------------------------------------------------------------
module bounded_set_table_unit
  import bst_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  bst_req_if.sink          req_i,
  bst_rsp_if.source        rsp_o
);

  bst_cmd_t cmd;
  bst_sts_t sts;
  logic     ready;

  assign req_i.ready = ready;

  // Request sequencer.
  bst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_mode_i  (req_i.mode),
    .req_ready_o (ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage, counters and output register.
  bst_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .element_i   (req_i.element),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== src/bst_datapath.sv =====
// ----------------------------------------------------------------------------
// bst_datapath: entry memory, counters and result registers
// Stores the elements in a single-port-write, registered-read memory and
// runs the scan and compaction pointers under controller commands.
// ----------------------------------------------------------------------------
module bst_datapath
  import bst_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i,
  input  logic signed [ELEM_W-1:0] element_i,
  input  bst_cmd_t                 cmd_i,
  output bst_sts_t                 sts_o,
  bst_rsp_if.source                rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  logic signed [ELEM_W-1:0] mem [DEPTH];
  logic signed [ELEM_W-1:0] rdata_q;
  logic signed [ELEM_W-1:0] elem_q;
  logic [CAP_W-1:0]         cap_q;
  logic [CW-1:0]            fill_q, fill_d;
  logic [CW-1:0]            iter_q, iter_d;
  logic [CW-1:0]            ptr_q, ptr_d;
  logic [CW-1:0]            cmp_q, cmp_d;
  logic                     vld_q, vld_d;
  logic                     res_ok_q;
  logic signed [ELEM_W-1:0] res_val_q;
  logic                     out_valid_q;
  logic                     out_ok_q;
  logic signed [ELEM_W-1:0] out_val_q;
  logic [CNT_W-1:0]         out_cnt_q;
  logic                     out_empty_q;

  logic [LW-1:0] cap_l, fill_l, limit;
  logic          issue;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic signed [ELEM_W-1:0] wr_data;
  logic [CW-1:0] last_idx, dst_idx;

  // Effective capacity is the smaller of the register and the depth.
  assign cap_l  = LW'(cap_q);
  assign fill_l = LW'(fill_q);
  assign limit  = (cap_l < DEPTH_L) ? cap_l : DEPTH_L;

  assign issue    = cmd_i.step && (ptr_q < fill_q);
  assign last_idx = fill_q - CW'(1);
  assign dst_idx  = cmp_q - CW'(1);

  // Status toward the controller.
  always_comb begin
    sts_o.full      = fill_l >= limit;
    sts_o.empty     = fill_q == '0;
    sts_o.iter_end  = iter_q >= fill_q;
    sts_o.match     = vld_q && (rdata_q == elem_q);
    sts_o.scan_done = !vld_q && (ptr_q >= fill_q);
    sts_o.out_free  = !out_valid_q || rsp_o.ready;
  end

  // Read and write port selection.
  always_comb begin
    rd_en   = cmd_i.fetch_last || cmd_i.fetch_iter || issue;
    rd_addr = ptr_q[AW-1:0];
    if (cmd_i.fetch_last) begin
      rd_addr = last_idx[AW-1:0];
    end else if (cmd_i.fetch_iter) begin
      rd_addr = iter_q[AW-1:0];
    end
    wr_en   = cmd_i.append || (cmd_i.shift_wr && vld_q);
    wr_addr = fill_q[AW-1:0];
    wr_data = elem_q;
    if (!cmd_i.append) begin
      wr_addr = dst_idx[AW-1:0];
      wr_data = rdata_q;
    end
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Next values of the counters and the scan pointers.
  always_comb begin
    fill_d = fill_q;
    iter_d = iter_q;
    ptr_d  = ptr_q;
    cmp_d  = cmp_q;
    vld_d  = vld_q;
    if (cmd_i.append) begin
      fill_d = fill_q + CW'(1);
    end else if (cmd_i.drop) begin
      fill_d = fill_q - CW'(1);
    end
    if (cmd_i.iter_clr) begin
      iter_d = '0;
    end else if (cmd_i.iter_inc) begin
      iter_d = iter_q + CW'(1);
    end
    if (cmd_i.accept) begin
      ptr_d = '0;
      vld_d = 1'b0;
    end else if (cmd_i.shift_start) begin
      ptr_d = cmp_q + CW'(1);
      vld_d = 1'b0;
    end else if (cmd_i.step) begin
      vld_d = issue;
      if (issue) begin
        cmp_d = ptr_q;
        ptr_d = ptr_q + CW'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      fill_q      <= '0;
      iter_q      <= '0;
      ptr_q       <= '0;
      cmp_q       <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      fill_q <= fill_d;
      iter_q <= iter_d;
      ptr_q  <= ptr_d;
      cmp_q  <= cmp_d;
      vld_q  <= vld_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operand, result and output payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      elem_q <= element_i;
    end
    if (cmd_i.res_load) begin
      res_ok_q  <= cmd_i.res_ok;
      res_val_q <= cmd_i.res_data ? rdata_q : '0;
    end
    if (cmd_i.load_out) begin
      out_ok_q    <= res_ok_q;
      out_val_q   <= res_val_q;
      out_cnt_q   <= fill_l[CNT_W-1:0];
      out_empty_q <= fill_q == '0;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.ok        = out_ok_q;
  assign rsp_o.value     = out_val_q;
  assign rsp_o.count     = out_cnt_q;
  assign rsp_o.empty_res = out_empty_q;

endmodule

// ===== src/bst_ctrl.sv =====
// ----------------------------------------------------------------------------
// bst_ctrl: request sequencer of the bounded set table
// Decodes each request beat and steps the datapath through search,
// compaction, fetch and response.
// ----------------------------------------------------------------------------
module bst_ctrl
  import bst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic [MODE_W-1:0] req_mode_i,
  output logic              req_ready_o,
  input  bst_sts_t          sts_i,
  output bst_cmd_t          cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [MODE_W-1:0] mode_q;

  assign req_ready_o = state_q == S_IDLE;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_RESP;
          case (req_mode_i) inside
            MODE_INSERT: begin
              if (sts_i.full) begin
                cmd_o.res_load = 1'b1;
              end else begin
                state_d = S_SEARCH;
              end
            end
            MODE_REMOVE, MODE_MEMBER: begin
              state_d = S_SEARCH;
            end
            MODE_POP: begin
              if (sts_i.empty) begin
                cmd_o.res_load = 1'b1;
              end else begin
                cmd_o.fetch_last = 1'b1;
                state_d          = S_FETCH;
              end
            end
            MODE_ITER_RST: begin
              cmd_o.iter_clr = 1'b1;
              cmd_o.res_load = 1'b1;
              cmd_o.res_ok   = 1'b1;
            end
            MODE_ITER_NEXT: begin
              if (sts_i.iter_end) begin
                cmd_o.res_load = 1'b1;
              end else begin
                cmd_o.fetch_iter = 1'b1;
                state_d          = S_FETCH;
              end
            end
            default: begin
              cmd_o.res_load = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (sts_i.match) begin
          if (mode_q == MODE_REMOVE) begin
            cmd_o.shift_start = 1'b1;
            state_d           = S_SHIFT;
          end else begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_ok   = 1'b1;
            state_d        = S_RESP;
          end
        end else if (sts_i.scan_done) begin
          cmd_o.res_load = 1'b1;
          if (mode_q == MODE_INSERT) begin
            cmd_o.append = 1'b1;
            cmd_o.res_ok = 1'b1;
          end
          state_d = S_RESP;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.scan_done) begin
          cmd_o.drop     = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_ok   = 1'b1;
          state_d        = S_RESP;
        end else begin
          cmd_o.step     = 1'b1;
          cmd_o.shift_wr = 1'b1;
        end
      end
      S_FETCH: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_ok   = 1'b1;
        cmd_o.res_data = 1'b1;
        if (mode_q == MODE_POP) begin
          cmd_o.drop = 1'b1;
        end else begin
          cmd_o.iter_inc = 1'b1;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The mode of the request in progress.
  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      mode_q <= req_mode_i;
    end
  end

endmodule

// ===== bench/bounded_set_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_set_table_unit_tb: self-checking regression of the bounded set table
// A queue-fed driver offers request beats with random gaps, a receiver stalls
// the result channel at random and once for a long stretch, and a monitor
// predicts every accepted request and compares each result beat field by
// field. The capacity register is swept through several values between phases.
// ----------------------------------------------------------------------------
module bounded_set_table_unit_tb;
  import bst_pkg::*;

  localparam int unsigned SET_DEPTH   = 8;
  localparam int unsigned IDLE_PCT    = 28;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 135;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned MAX_REPORTS = 10;

  // The two mode codes that the block treats as no operation.
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ELEM_W-1:0] element;
  } set_req_t;

  typedef struct packed {
    logic              ok;
    logic [ELEM_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic              empty_res;
  } set_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  bst_req_if req_if ();
  bst_rsp_if rsp_if ();

  bounded_set_table_unit #(.DEPTH(SET_DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Shadow copy of the set state and the capacity register.
  logic [ELEM_W-1:0] set_mem [SET_DEPTH];
  int unsigned       set_fill;
  int unsigned       iter_ptr;
  logic [CAP_W-1:0]  set_cap;

  set_req_t    pending_q [$];
  set_result_t expected_rsp_q [$];

  logic        req_taken;
  logic        quiet;
  logic        hold_armed;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned queued_cnt;
  int unsigned cap_writes;
  int unsigned error_count = 0;

  logic [ELEM_W-1:0] elem_pool [12] = '{
    32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
    32'h0000_0001, 32'h8000_0001, 32'h7fff_fffe, 32'h5a5a_a5a5,
    32'ha5a5_5a5a, 32'h0000_0100, 32'hdead_0042, 32'h1234_5678
  };

  // Apply one request to the shadow set and return the result it gives.
  function automatic set_result_t set_apply(logic [MODE_W-1:0] op, logic [ELEM_W-1:0] elem);
    set_result_t r;
    int unsigned lim;
    int unsigned pos;
    r   = '0;
    lim = (set_cap < SET_DEPTH) ? set_cap : SET_DEPTH;
    pos = set_fill;
    for (int unsigned i = 0; i < set_fill; i++) begin
      if (set_mem[i] == elem && pos == set_fill) begin
        pos = i;
      end
    end
    case (op)
      MODE_INSERT: begin
        // A full set refuses even an element that is already stored.
        if (set_fill < lim) begin
          r.ok = 1'b1;
          if (pos == set_fill) begin
            set_mem[set_fill] = elem;
            set_fill++;
          end
        end
      end
      MODE_REMOVE: begin
        if (pos < set_fill) begin
          for (int unsigned j = pos; j + 1 < set_fill; j++) begin
            set_mem[j] = set_mem[j + 1];
          end
          set_fill--;
          r.ok = 1'b1;
        end
      end
      MODE_MEMBER: begin
        r.ok = (pos < set_fill);
      end
      MODE_POP: begin
        if (set_fill > 0) begin
          r.value = set_mem[set_fill - 1];
          set_fill--;
          r.ok = 1'b1;
        end
      end
      MODE_ITER_RST: begin
        iter_ptr = 0;
        r.ok     = 1'b1;
      end
      MODE_ITER_NEXT: begin
        // The pointer is left alone by removals, so it may sit past the end.
        if (iter_ptr < set_fill) begin
          r.value = set_mem[iter_ptr];
          iter_ptr++;
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count     = CNT_W'(set_fill);
    r.empty_res = (set_fill == 0);
    return r;
  endfunction

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Request driver: holds a beat until it is taken, then maybe idles.
  always @(negedge clk_i) begin : req_driver
    set_req_t beat;
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.mode    <= '0;
      req_if.element <= '0;
    end else if (!req_if.valid || req_taken) begin
      if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        beat = pending_q.pop_front();
        req_if.valid   <= 1'b1;
        req_if.mode    <= beat.mode;
        req_if.element <= beat.element;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, and one long hold-off while requests keep coming.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      rsp_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: predict each accepted request and check each accepted result beat.
  always @(posedge clk_i) begin : monitor
    set_result_t exp_r;
    if (!rst_ni) begin
      req_taken <= 1'b0;
      set_fill = 0;
      iter_ptr = 0;
      set_cap  = CAP_RESET;
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      if (cfg_we) begin
        set_cap = cfg_wdata;
      end
      if (req_if.valid && req_if.ready) begin
        expected_rsp_q.push_back(set_apply(req_if.mode, req_if.element));
        accepted_cnt++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("ERROR: result beat with nothing expected: ok=%0b value=%h count=%0d empty=%0b",
                     rsp_if.ok, rsp_if.value, rsp_if.count, rsp_if.empty_res);
          end
        end else begin
          exp_r = expected_rsp_q.pop_front();
          checked_cnt++;
          if (rsp_if.ok !== exp_r.ok || rsp_if.value !== exp_r.value ||
              rsp_if.count !== exp_r.count || rsp_if.empty_res !== exp_r.empty_res) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("ERROR: result %0d: ok %0b/%0b value %h/%h count %0d/%0d empty %0b/%0b",
                       checked_cnt, exp_r.ok, rsp_if.ok, exp_r.value, rsp_if.value,
                       exp_r.count, rsp_if.count, exp_r.empty_res, rsp_if.empty_res);
            end
          end
        end
      end
    end
  end

  task automatic queue_req(logic [MODE_W-1:0] op, logic [ELEM_W-1:0] elem);
    set_req_t r;
    r.mode    = op;
    r.element = elem;
    pending_q.push_back(r);
    queued_cnt++;
  endtask

  // Wait until every queued beat has gone in and every result has come back.
  task automatic wait_drained();
    while (pending_q.size() != 0 || req_if.valid || expected_rsp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cap_writes++;
  endtask

  function automatic logic [ELEM_W-1:0] pick_elem();
    if ($urandom_range(99) < 72) begin
      return elem_pool[$urandom_range(11)];
    end
    return $urandom;
  endfunction

  // Main sequence: reset, directed checks, then random phases over capacities.
  initial begin : stimulus
    logic [CAP_W-1:0] caps [8];
    int unsigned      n;
    int unsigned      r;
    caps = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd8, 4'd5, 4'd2, 4'd12};

    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    quiet          = 1'b0;
    hold_armed     = 1'b0;
    queued_cnt     = 0;
    cap_writes     = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty set: every operation that needs an element must fail.
    queue_req(MODE_POP, 32'h0);
    queue_req(MODE_ITER_NEXT, 32'h0);
    queue_req(MODE_REMOVE, 32'h7fff_ffff);
    queue_req(MODE_MEMBER, 32'h8000_0000);
    queue_req(MODE_SPARE_A, 32'hffff_ffff);
    queue_req(MODE_SPARE_B, 32'h8000_0000);
    // Extremes of the element, a duplicate insert and a membership hit.
    queue_req(MODE_INSERT, 32'h8000_0000);
    queue_req(MODE_INSERT, 32'h7fff_ffff);
    queue_req(MODE_INSERT, 32'h0000_0000);
    queue_req(MODE_INSERT, 32'hffff_ffff);
    queue_req(MODE_INSERT, 32'h7fff_ffff);
    queue_req(MODE_MEMBER, 32'hffff_ffff);
    // Walk two steps, then remove the head: the pointer does not move back.
    queue_req(MODE_ITER_RST, 32'h0);
    queue_req(MODE_ITER_NEXT, 32'h0);
    queue_req(MODE_ITER_NEXT, 32'h0);
    queue_req(MODE_REMOVE, 32'h8000_0000);
    queue_req(MODE_ITER_NEXT, 32'h0);
    queue_req(MODE_ITER_NEXT, 32'h0);
    queue_req(MODE_POP, 32'h0);
    // Fill to the limit, then a present element is refused while full.
    for (int i = 1; i <= 6; i++) begin
      queue_req(MODE_INSERT, elem_pool[i + 3]);
    end
    queue_req(MODE_INSERT, 32'h7fff_ffff);
    wait_drained();

    // Random phases, one per capacity setting.
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      quiet = (p == 4);
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 8) begin
          // A full iteration walk, usually running past the end.
          queue_req(MODE_ITER_RST, $urandom);
          n++;
          repeat ($urandom_range(1, 9)) begin
            queue_req(MODE_ITER_NEXT, $urandom);
            n++;
          end
        end else if (r < 43) begin
          queue_req(MODE_INSERT, pick_elem());
          n++;
        end else if (r < 63) begin
          queue_req(MODE_REMOVE, pick_elem());
          n++;
        end else if (r < 77) begin
          queue_req(MODE_MEMBER, pick_elem());
          n++;
        end else if (r < 85) begin
          queue_req(MODE_POP, $urandom);
          n++;
        end else if (r < 93) begin
          queue_req(MODE_ITER_NEXT, $urandom);
          n++;
        end else if (r < 96) begin
          queue_req(MODE_ITER_RST, $urandom);
          n++;
        end else begin
          queue_req(3'($urandom_range(6, 7)), $urandom);
          n++;
        end
      end
      if (p == 2) begin
        hold_armed = 1'b1;
      end
      wait_drained();
    end

    $display("Ran %0d requests over %0d capacity writes; %0d result beats checked.",
             accepted_cnt, cap_writes, checked_cnt);
    $display("Covered all modes, element extremes, full and empty sets and a long output stall.");
    if (error_count == 0) begin
      $display("bounded_set_table_unit regression: pass");
    end else begin
      $display("bounded_set_table_unit regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4000000;
    $display("Timeout with %0d results still expected.", expected_rsp_q.size());
    $display("bounded_set_table_unit regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
src/bst_pkg.sv
src/bst_req_if.sv
src/bst_rsp_if.sv
src/bst_datapath.sv
src/bst_ctrl.sv
src/bounded_set_table_unit.sv
bench/bounded_set_table_unit_tb.sv
